### hw/rtl/ffha_pkg.sv
// ffha_pkg: shared codes for the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;
    // request kinds
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;
    // status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_NULL  = 3'd1;
    localparam logic [2:0] ST_NOFIT = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    // one chunk table row
    typedef struct packed {
        logic [15:0] start;
        logic [15:0] bytes;
        logic        busy;
    } t_chunk;
endpackage
`default_nettype wire

### hw/rtl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: top level, sequencer over one chunk table memory
// depends on ffha_pkg
//
// usage: raise i_start with i_kind, i_req_size, i_block_address while o_busy
// is low; the item is taken at that edge and o_busy rises. One result appears
// with o_done high for one cycle, carrying o_status, o_result_address and
// o_result_size; the receiver cannot stall it. o_busy falls as o_done ends.
// The chunk table is a memory of MAX_CHUNKS rows with one read and one write
// port; each row visited is read in S_RD and acted on in S_CHK.
// An allocate walk may also shift rows up to open a slot on a split; a free
// that merges with both neighbours closes two gaps.
// reset: the table holds one free chunk covering the heap; only row 0 is
// written by reset (in the S_INIT state), the count is one.
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES   = 65536,
    parameter int MAX_CHUNKS   = 64,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [1:0]  i_kind,
    input  wire  [15:0] i_req_size,
    input  wire  [15:0] i_block_address,
    output logic        o_busy,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [15:0] o_result_address,
    output logic [15:0] o_result_size
);
    localparam int IW = $clog2(MAX_CHUNKS);
    localparam int CW = IW + 1;
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);
    localparam logic [16:0] AMASK = 17'(ALIGN_BYTES - 1);
    localparam logic [15:0] INIT_BYTES = 16'(HEAP_BYTES - 2 * HEADER_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_RD, S_CHK, S_OPEN_RD, S_OPEN_WR, S_SPLIT,
        S_NXT_RD, S_NXT_CHK, S_PRV_RD, S_PRV_CHK, S_CLOSE_RD, S_CLOSE_WR,
        S_FIN, S_DONE
    } t_state;

    // chunk table memory
    t_chunk r_mem [MAX_CHUNKS];
    t_chunk r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_wa, mem_ra;
    t_chunk        mem_wd;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd <= r_mem[mem_ra];
    end

    t_state r_state, n_state;
    logic [1:0]  r_kind;
    logic [16:0] r_need;
    logic [15:0] r_addr;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_i, n_i;       // current chunk index
    logic [CW-1:0] r_k, n_k;       // shift index
    logic [CW-1:0] r_gap, n_gap;   // row to remove
    t_chunk r_cur, n_cur;          // chunk being worked on
    logic [2:0]  r_st, n_st;
    logic [15:0] r_ra, n_ra, r_rs, n_rs;
    logic n_done;
    logic r_done_q;

    // shared adder/comparator unit
    logic [16:0] alu_a, alu_b, alu_sum;
    assign alu_sum = alu_a + alu_b;

    always_comb begin
        n_state = r_state; n_count = r_count; n_i = r_i; n_k = r_k;
        n_gap = r_gap; n_cur = r_cur; n_st = r_st; n_ra = r_ra; n_rs = r_rs;
        n_done = 1'b0;
        mem_we = 1'b0; mem_wa = '0; mem_ra = '0; mem_wd = r_cur;
        alu_a = '0; alu_b = '0;
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wd = '{start: 16'(HEADER_BYTES), bytes: INIT_BYTES, busy: 1'b0};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                n_i = '0; n_st = ST_OK; n_ra = '0; n_rs = '0;
                mem_ra = '0;
                if (i_start) n_state = S_RD;
            end
            S_RD: begin
                // fetch row r_i; at r_i zero also check for nulls
                mem_ra = r_i[IW-1:0];
                if (r_i == '0 && r_kind == KIND_ALLOC && r_need == '0) begin
                    n_st = ST_NULL; n_state = S_FIN;
                end else if (r_i == '0 && r_kind != KIND_ALLOC && r_addr == '0
                             && r_kind != KIND_RSVD) begin
                    n_st = ST_NULL; n_state = S_FIN;
                end else if (r_kind == KIND_RSVD) begin
                    n_st = ST_BAD; n_state = S_FIN;
                end else if (r_i >= r_count) begin
                    n_st = (r_kind == KIND_ALLOC) ? ST_NOFIT : ST_BAD;
                    n_state = S_FIN;
                end else n_state = S_CHK;
            end
            S_CHK: begin
                n_cur = r_rd;
                n_state = S_RD; n_i = r_i + 1'b1;
                if (r_kind == KIND_ALLOC) begin
                    alu_a = r_need; alu_b = HDR;
                    if (!r_rd.busy && {1'b0, r_rd.bytes} >= alu_sum) begin
                        n_i = r_i;
                        if ({1'b0, r_rd.bytes} >= alu_sum + HDR) begin
                            if (r_count >= MAXC) begin
                                n_st = ST_FULL; n_state = S_FIN;
                            end else begin
                                n_k = r_count; n_state = S_OPEN_RD;
                            end
                        end else begin
                            n_cur.busy = 1'b1; n_state = S_SPLIT;
                        end
                    end
                end else begin
                    alu_a = {1'b0, r_rd.start}; alu_b = HDR;
                    if (alu_sum[15:0] == r_addr && !alu_sum[16]) begin
                        n_i = r_i;
                        if (r_kind == KIND_QUERY) begin
                            n_rs = r_rd.bytes; n_state = S_FIN;
                        end else if (!r_rd.busy) begin
                            n_st = ST_BAD; n_state = S_FIN;
                        end else begin
                            n_cur.busy = 1'b0; n_state = S_NXT_RD;
                        end
                    end
                end
            end
            // shift rows up: row k-1 to row k, down to k = i+2
            S_OPEN_RD: begin
                mem_ra = IW'(r_k - 1'b1);
                n_state = (r_k > r_i + 1'b1) ? S_OPEN_WR : S_SPLIT;
            end
            S_OPEN_WR: begin
                mem_we = 1'b1; mem_wa = r_k[IW-1:0]; mem_wd = r_rd;
                n_k = r_k - 1'b1; n_state = S_OPEN_RD;
            end
            S_SPLIT: begin
                // write allocated row; on a split also write the remainder row
                alu_a = {1'b0, r_cur.start} + HDR; alu_b = r_need;
                n_ra = 16'(alu_a);
                if (!r_cur.busy) begin
                    mem_we = 1'b1; mem_wa = IW'(r_i + 1'b1);
                    mem_wd = '{start: alu_sum[15:0],
                               bytes: 16'(r_cur.bytes - r_need[15:0] - HDR[15:0]),
                               busy: 1'b0};
                    n_cur.bytes = r_need[15:0]; n_cur.busy = 1'b1;
                    n_count = r_count + 1'b1;
                end else begin
                    mem_we = 1'b1; mem_wa = r_i[IW-1:0]; mem_wd = r_cur;
                    n_state = S_FIN;
                end
            end
            S_NXT_RD: begin
                mem_ra = IW'(r_i + 1'b1);
                n_state = (r_i + 1'b1 < r_count) ? S_NXT_CHK : S_PRV_RD;
            end
            S_NXT_CHK: begin
                n_state = S_PRV_RD;
                if (!r_rd.busy) begin
                    alu_a = {1'b0, r_cur.bytes} + HDR; alu_b = {1'b0, r_rd.bytes};
                    n_cur.bytes = alu_sum[15:0];
                    n_gap = r_i + 1'b1;
                end
            end
            S_PRV_RD: begin
                mem_ra = IW'(r_i - 1'b1);
                n_state = (r_i != '0) ? S_PRV_CHK : S_CLOSE_RD;
                mem_we = 1'b1; mem_wa = r_i[IW-1:0]; mem_wd = r_cur;
            end
            S_PRV_CHK: begin
                n_state = S_CLOSE_RD;
                if (!r_rd.busy) begin
                    alu_a = {1'b0, r_rd.bytes} + HDR; alu_b = {1'b0, r_cur.bytes};
                    n_cur = r_rd; n_cur.bytes = alu_sum[15:0];
                    mem_we = 1'b1; mem_wa = IW'(r_i - 1'b1);
                    mem_wd = n_cur;
                    // remove the freed row too; when a next merge also removed
                    // a row, close that gap first (it lies above)
                    if (r_gap == '0) n_gap = r_i;
                    else n_k = r_i;
                end
                if (r_rd.busy || r_gap == '0) n_k = '0;
            end
            // close the gap at r_gap; then close a second pending gap at r_k
            S_CLOSE_RD: begin
                if (r_gap == '0) n_state = S_FIN;
                else if (r_gap + 1'b1 < r_count) begin
                    mem_ra = IW'(r_gap + 1'b1); n_state = S_CLOSE_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_gap = r_k; n_k = '0;
                end
            end
            S_CLOSE_WR: begin
                mem_we = 1'b1; mem_wa = r_gap[IW-1:0]; mem_wd = r_rd;
                n_gap = r_gap + 1'b1; n_state = S_CLOSE_RD;
            end
            S_FIN: begin
                if (r_st != ST_OK) begin n_ra = '0; n_rs = '0; end
                if (r_kind != KIND_ALLOC) n_ra = '0;
                n_done = 1'b1; n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_count <= CW'(1); r_done_q <= 1'b0;
            r_gap <= '0; r_k <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_done_q <= n_done;
            r_gap <= (r_state == S_IDLE) ? '0 : n_gap;
            r_k <= (r_state == S_IDLE) ? '0 : n_k;
        end
        r_i <= n_i; r_cur <= n_cur; r_st <= n_st; r_ra <= n_ra; r_rs <= n_rs;
        if (r_state == S_IDLE && i_start) begin
            r_kind <= i_kind; r_addr <= i_block_address;
            r_need <= (17'(i_req_size) + AMASK) & ~AMASK;
        end
        if (n_done) begin
            o_status <= n_st; o_result_address <= n_ra; o_result_size <= n_rs;
        end
    end

    assign o_done = r_done_q;
    assign o_busy = (r_state != S_IDLE);

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CW'(1) && r_count <= MAXC) else $error("chunk count out of range");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than one cycle");
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy) else $error("done while idle");
endmodule
`default_nettype wire

### test/tb_first_fit_heap_allocator.sv
// tb_first_fit_heap_allocator: self-checking bench for the first-fit heap allocator
// depends on ffha_pkg and first_fit_heap_allocator; keeps its own chunk table
// and checks every result strobe against the expected status, address and size
`default_nettype none
module tb_first_fit_heap_allocator;
    import ffha_pkg::*;

    localparam int HEAP   = 65536;
    localparam int MAXC   = 64;
    localparam int HDR    = 32;
    localparam int ALIGNB = 8;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] addr;
        logic [15:0] size;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_kind = KIND_ALLOC;
    logic [15:0] i_req_size = '0;
    logic [15:0] i_block_address = '0;
    wire         o_busy;
    wire         o_done;
    wire  [2:0]  o_status;
    wire  [15:0] o_result_address;
    wire  [15:0] o_result_size;

    first_fit_heap_allocator u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_kind           (i_kind),
        .i_req_size       (i_req_size),
        .i_block_address  (i_block_address),
        .o_busy           (o_busy),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_result_address (o_result_address),
        .o_result_size    (o_result_size)
    );

    always #4 i_clk = ~i_clk;

    // own copy of the chunk table
    int chunk_at[MAXC];
    int chunk_len[MAXC];
    bit chunk_used[MAXC];
    int n_chunks;

    t_outcome pending_q[$];
    logic [15:0] live_q[$];
    int n_items, n_results, n_errors, burst_left;
    int n_full, n_merge_ok;

    // remove one row, closing the gap
    function automatic void table_drop(int idx);
        for (int k = idx; k + 1 < n_chunks; k++) begin
            chunk_at[k]   = chunk_at[k + 1];
            chunk_len[k]  = chunk_len[k + 1];
            chunk_used[k] = chunk_used[k + 1];
        end
        n_chunks--;
    endfunction

    function automatic int table_find(int addr);
        for (int i = 0; i < n_chunks; i++)
            if (chunk_at[i] + HDR == addr) return i;
        return -1;
    endfunction

    // expected outcome of one item, updating the table
    function automatic t_outcome heap_apply(logic [1:0] kind, int req, int addr);
        t_outcome r;
        int need, i;
        r.status = ST_BAD; r.addr = '0; r.size = '0;
        case (kind)
            KIND_ALLOC: begin
                if (req == 0) begin
                    r.status = ST_NULL;
                end else begin
                    need = ((req + ALIGNB - 1) / ALIGNB) * ALIGNB;
                    r.status = ST_NOFIT;
                    for (i = 0; i < n_chunks; i++) begin
                        if (chunk_used[i] || chunk_len[i] < need + HDR) continue;
                        if (chunk_len[i] >= need + 2 * HDR) begin
                            if (n_chunks >= MAXC) begin
                                r.status = ST_FULL;
                                break;
                            end
                            for (int k = n_chunks; k > i + 1; k--) begin
                                chunk_at[k]   = chunk_at[k - 1];
                                chunk_len[k]  = chunk_len[k - 1];
                                chunk_used[k] = chunk_used[k - 1];
                            end
                            chunk_at[i + 1]   = (chunk_at[i] + HDR + need) & 16'hffff;
                            chunk_len[i + 1]  = (chunk_len[i] - need - HDR) & 16'hffff;
                            chunk_used[i + 1] = 1'b0;
                            chunk_len[i]      = need & 16'hffff;
                            n_chunks++;
                        end
                        chunk_used[i] = 1'b1;
                        r.status = ST_OK;
                        r.addr = 16'((chunk_at[i] + HDR) & 16'hffff);
                        break;
                    end
                end
            end
            KIND_FREE: begin
                i = table_find(addr);
                if (addr == 0) r.status = ST_NULL;
                else if (i < 0 || !chunk_used[i]) r.status = ST_BAD;
                else begin
                    r.status = ST_OK;
                    chunk_used[i] = 1'b0;
                    if (i + 1 < n_chunks && !chunk_used[i + 1]) begin
                        chunk_len[i] = (chunk_len[i] + HDR + chunk_len[i + 1]) & 16'hffff;
                        table_drop(i + 1);
                        n_merge_ok++;
                    end
                    if (i > 0 && !chunk_used[i - 1]) begin
                        chunk_len[i - 1] = (chunk_len[i - 1] + HDR + chunk_len[i]) & 16'hffff;
                        table_drop(i);
                        n_merge_ok++;
                    end
                end
            end
            KIND_QUERY: begin
                i = table_find(addr);
                if (addr == 0) r.status = ST_NULL;
                else if (i < 0) r.status = ST_BAD;
                else begin
                    r.status = ST_OK;
                    r.size = 16'(chunk_len[i]);
                end
            end
            default: r.status = ST_BAD;
        endcase
        return r;
    endfunction

    // send one item, predict it at the accepting edge, then maybe pause
    task automatic send_item(logic [1:0] kind, logic [15:0] req, logic [15:0] addr);
        t_outcome r;
        i_start <= 1'b1;
        i_kind <= kind;
        i_req_size <= req;
        i_block_address <= addr;
        do @(negedge i_clk); while (o_busy);
        @(posedge i_clk);
        r = heap_apply(kind, req, addr);
        pending_q.push_back(r);
        n_items++;
        if (r.status == ST_FULL) n_full++;
        if (r.status == ST_OK && kind == KIND_ALLOC) live_q.push_back(r.addr);
        if (r.status == ST_OK && kind == KIND_FREE)
            foreach (live_q[j]) if (live_q[j] == addr) begin
                live_q.delete(j);
                break;
            end
        // bursts with random gaps between them
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
        end
    endtask

    task automatic free_all();
        while (live_q.size() > 0)
            send_item(KIND_FREE, 16'($urandom), live_q[$urandom_range(0, live_q.size() - 1)]);
    endtask

    // result checking, sampled away from the driving edge
    always @(negedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_done) begin
            n_results++;
            if (pending_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("ERROR: result with nothing expected");
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status || o_result_address !== e.addr ||
                    o_result_size !== e.size) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: result %0d exp st=%0d a=%0d s=%0d got st=%0d a=%0d s=%0d",
                                 n_results, e.status, e.addr, e.size,
                                 o_status, o_result_address, o_result_size);
                end
            end
        end
    end

    // zero sizes, nulls, reserved kind, extremes and all operations
    task automatic test_directed();
        logic [15:0] a, b, c;
        send_item(KIND_ALLOC, 16'd0, 16'hffff);
        send_item(KIND_FREE, 16'hffff, 16'd0);
        send_item(KIND_QUERY, 16'hffff, 16'd0);
        send_item(KIND_RSVD, 16'hffff, 16'hffff);
        send_item(KIND_QUERY, 16'd0, 16'(2 * HDR));
        send_item(KIND_ALLOC, 16'hffff, 16'd0);
        send_item(KIND_ALLOC, 16'd1, 16'd0);
        a = live_q[$];
        send_item(KIND_ALLOC, 16'd9, 16'd0);
        b = live_q[$];
        send_item(KIND_ALLOC, 16'd100, 16'd0);
        c = live_q[$];
        send_item(KIND_QUERY, 16'd0, a);
        send_item(KIND_QUERY, 16'd0, 16'(c + 104 + HDR));
        send_item(KIND_FREE, 16'd0, 16'hffff);
        send_item(KIND_FREE, 16'd0, 16'(a + 1));
        send_item(KIND_FREE, 16'd0, a);
        send_item(KIND_FREE, 16'd0, a);
        send_item(KIND_QUERY, 16'd0, a);
        send_item(KIND_FREE, 16'd0, c);
        send_item(KIND_FREE, 16'd0, b);
        // split off a small remainder, refuse 40 bytes, then fill it unsplit
        send_item(KIND_ALLOC, 16'(HEAP - 5 * HDR), 16'd0);
        send_item(KIND_ALLOC, 16'd40, 16'd0);
        send_item(KIND_ALLOC, 16'd1, 16'd0);
        free_all();
        send_item(KIND_ALLOC, 16'(HEAP - 3 * HDR), 16'd0);
        free_all();
    endtask

    // fill the table until a split is refused
    task automatic test_table_full();
        int guard;
        guard = 0;
        while (n_chunks < MAXC && guard < 80) begin
            send_item(KIND_ALLOC, 16'($urandom_range(1, 24)), 16'd0);
            guard++;
        end
        send_item(KIND_ALLOC, 16'd8, 16'd0);
        send_item(KIND_ALLOC, 16'hffff, 16'd0);
        // free every other block so later frees merge on both sides
        for (int j = live_q.size() - 1; j >= 0; j -= 2)
            send_item(KIND_FREE, 16'd0, live_q[j]);
        send_item(KIND_ALLOC, 16'd8, 16'd0);
        free_all();
    endtask

    // mostly well-formed alloc/free/query traffic with some noise
    task automatic test_random(int count);
        int sel;
        logic [15:0] a;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                a = $urandom_range(0, 7) == 0 ? 16'($urandom)
                                               : 16'($urandom_range(1, 600));
                send_item(KIND_ALLOC, a, 16'($urandom));
            end else if (sel < 70 && live_q.size() > 0) begin
                send_item(KIND_FREE, 16'($urandom),
                          live_q[$urandom_range(0, live_q.size() - 1)]);
            end else if (sel < 85 && live_q.size() > 0) begin
                a = live_q[$urandom_range(0, live_q.size() - 1)];
                if ($urandom_range(0, 3) == 0) a = 16'(a + 8 * $urandom_range(1, 80));
                send_item(KIND_QUERY, 16'($urandom), a);
            end else begin
                send_item(2'($urandom), 16'($urandom),
                          $urandom_range(0, 1) ? 16'($urandom) : 16'd0);
            end
            if (live_q.size() > 50) free_all();
        end
        free_all();
    endtask

    initial begin
        n_chunks = 1;
        chunk_at[0] = HDR;
        chunk_len[0] = HEAP - 2 * HDR;
        chunk_used[0] = 1'b0;
        n_items = 0; n_results = 0; n_errors = 0; burst_left = 0;
        n_full = 0; n_merge_ok = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);
        test_directed();
        test_table_full();
        test_random(400);
        i_start <= 1'b0;
        while (pending_q.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d items, %0d results, %0d table-full refusals, %0d merges",
                 n_items, n_results, n_full, n_merge_ok);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("tb_first_fit_heap_allocator OK");
        end else begin
            $display("%0d mismatches, %0d results missing", n_errors, pending_q.size());
            $display("tb_first_fit_heap_allocator NOT OK");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40000000;
        $display("timeout");
        $display("tb_first_fit_heap_allocator NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
hw/rtl/ffha_pkg.sv
hw/rtl/first_fit_heap_allocator.sv
test/tb_first_fit_heap_allocator.sv
